### src/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define BGCO_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

// Check a property on every clock edge, reset included.
`define BGCO_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

### src/bgco_pkg.sv
// Shared types and constants of the greedy bitset coloring block.
// No dependencies.
package bgco_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int VIDX_W       = 6;
    localparam int ROW_W        = 64;
    localparam int COLOUR_W     = 7;

    localparam logic [ROW_W-1:0] VMASK = (MAX_VERTICES >= ROW_W) ? {ROW_W{1'b1}} :
        ((64'd1 << MAX_VERTICES) - 64'd1);

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_COLOUR = 1'b1
    } opcode_t;

    typedef struct packed {
        logic              en;
        logic [VIDX_W-1:0] addr;
        logic [ROW_W-1:0]  data;
    } mem_wr_t;

endpackage

### src/bgco_adj_mem.sv
// Adjacency row memory: one write port, one read port with registered data.
// Depends on bgco_pkg.
module bgco_adj_mem (
    input  logic                          aclk,
    input  bgco_pkg::mem_wr_t             wr,
    input  logic [bgco_pkg::VIDX_W-1:0]   raddr,
    output logic [bgco_pkg::ROW_W-1:0]    rdata
);

    logic [bgco_pkg::ROW_W-1:0] mem [0:(1 << bgco_pkg::VIDX_W)-1];
    logic [bgco_pkg::ROW_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/bgco_lowest.sv
// Priority encoder: index of the lowest set bit of the class pool.
// Depends on bgco_pkg.
module bgco_lowest (
    input  logic [bgco_pkg::ROW_W-1:0]  pool,
    output logic [bgco_pkg::VIDX_W-1:0] idx
);

    always_comb begin
        idx = '0;
        for (int i = bgco_pkg::ROW_W - 1; i >= 0; i--) begin
            if (pool[i]) begin
                idx = bgco_pkg::VIDX_W'(i);
            end
        end
    end

endmodule

### src/bitset_greedy_colour_order.sv
// Top level of the greedy bitset coloring block: sequencer and result register.
// Depends on bgco_pkg, bgco_adj_mem, bgco_lowest.
//
//   channel  | ports        | fields (low bit first)
//   request  | s_t*         | tuser: opcode; tdata: row_index, row_bits, candidate_set
//   result   | m_t*         | tdata: vertex, colour; tlast: is_last; tuser: set_was_empty
//
// A row write goes to the adjacency memory on accept. An empty set gives its result in the
// cycle after accept. Coloring picks a vertex, then applies its row, a split set by the
// single registered read port of the adjacency memory. The memory has no reset and no
// clearing pass; the user must keep unwritten rows unread, the block does not enforce it.
// A result waiting on m_tready holds the sequencer before its next pick.
module bitset_greedy_colour_order (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,   // row_index[5:0], row_bits[69:6], candidate_set[133:70]
    input  logic         s_tuser,   // opcode[0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [15:0]  m_tdata,   // vertex[5:0], colour[12:6]
    output logic         m_tlast,
    output logic         m_tuser    // set_was_empty[0]
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_PICK  = 3'b010,
        ST_APPLY = 3'b100
    } state_t;

    state_t                           state_reg, state_next;
    logic [bgco_pkg::ROW_W-1:0]       left_reg, left_next;
    logic [bgco_pkg::ROW_W-1:0]       pool_reg, pool_next;
    logic [bgco_pkg::COLOUR_W-1:0]    colour_reg, colour_next;
    logic                             out_valid_reg, out_valid_next;
    logic [bgco_pkg::VIDX_W-1:0]      out_vertex_reg, out_vertex_next;
    logic [bgco_pkg::COLOUR_W-1:0]    out_colour_reg, out_colour_next;
    logic                             out_last_reg, out_last_next;
    logic                             out_empty_reg, out_empty_next;

    logic [bgco_pkg::VIDX_W-1:0]      pick_idx;
    logic [bgco_pkg::ROW_W-1:0]       pick_bit;
    logic [bgco_pkg::ROW_W-1:0]       left_after;
    logic [bgco_pkg::ROW_W-1:0]       pool_applied;
    logic [bgco_pkg::ROW_W-1:0]       row_q;
    logic [bgco_pkg::ROW_W-1:0]       cand;
    logic [bgco_pkg::VIDX_W-1:0]      in_row_index;
    bgco_pkg::opcode_t                in_opcode;
    bgco_pkg::mem_wr_t                mem_wr;
    logic                             in_acc;
    logic                             out_free;

    bgco_lowest u_lowest (
        .pool (pool_reg),
        .idx  (pick_idx)
    );

    bgco_adj_mem u_mem (
        .aclk  (aclk),
        .wr    (mem_wr),
        .raddr (pick_idx),
        .rdata (row_q)
    );

    assign out_free     = !out_valid_reg || m_tready;
    assign s_tready     = (state_reg == ST_IDLE) && out_free;
    assign in_acc       = s_tvalid && s_tready;
    assign in_opcode    = bgco_pkg::opcode_t'(s_tuser);
    assign in_row_index = s_tdata[5:0];
    assign cand         = s_tdata[133:70] & bgco_pkg::VMASK;
    assign pick_bit     = bgco_pkg::ROW_W'(1) << pick_idx;
    assign left_after   = left_reg & ~pick_bit;
    assign pool_applied = pool_reg & ~(row_q & bgco_pkg::VMASK);

    always_comb begin
        mem_wr.en   = in_acc && (in_opcode == bgco_pkg::OP_WRITE) &&
                      ({1'b0, in_row_index} < 7'(bgco_pkg::MAX_VERTICES));
        mem_wr.addr = in_row_index;
        mem_wr.data = s_tdata[69:6];
    end

    always_comb begin
        state_next      = state_reg;
        left_next       = left_reg;
        pool_next       = pool_reg;
        colour_next     = colour_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_vertex_next = out_vertex_reg;
        out_colour_next = out_colour_reg;
        out_last_next   = out_last_reg;
        out_empty_next  = out_empty_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc && (in_opcode == bgco_pkg::OP_COLOUR)) begin
                    if (cand == '0) begin
                        out_valid_next  = 1'b1;
                        out_vertex_next = '0;
                        out_colour_next = '0;
                        out_last_next   = 1'b1;
                        out_empty_next  = 1'b1;
                    end else begin
                        left_next   = cand;
                        pool_next   = cand;
                        colour_next = bgco_pkg::COLOUR_W'(1);
                        state_next  = ST_PICK;
                    end
                end
            end
            ST_PICK: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_vertex_next = pick_idx;
                    out_colour_next = colour_reg;
                    out_last_next   = (left_after == '0);
                    out_empty_next  = 1'b0;
                    left_next       = left_after;
                    pool_next       = pool_reg & ~pick_bit;
                    state_next      = ST_APPLY;
                end
            end
            ST_APPLY: begin
                if (left_reg == '0) begin
                    state_next = ST_IDLE;
                end else if (pool_applied == '0) begin
                    pool_next   = left_reg;
                    colour_next = colour_reg + bgco_pkg::COLOUR_W'(1);
                    state_next  = ST_PICK;
                end else begin
                    pool_next  = pool_applied;
                    state_next = ST_PICK;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        left_reg       <= left_next;
        pool_reg       <= pool_next;
        colour_reg     <= colour_next;
        out_vertex_reg <= out_vertex_next;
        out_colour_reg <= out_colour_next;
        out_last_reg   <= out_last_next;
        out_empty_reg  <= out_empty_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_colour_reg, out_vertex_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_empty_reg;

endmodule

### src/bgco_checker.sv
// Port-level checks of the greedy bitset coloring block, bound to its top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module bgco_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [15:0]  m_tdata,
    input logic         m_tlast,
    input logic         m_tuser
);

    `BGCO_ASSERT_ALWAYS(a_reset_clears_valid, aclk, !aresetn |=> !m_tvalid)
    `BGCO_ASSERT(a_result_holds, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    `BGCO_ASSERT(a_empty_is_last, aclk, aresetn, m_tvalid && m_tuser |-> m_tlast && (m_tdata == 16'd0))
    `BGCO_ASSERT(a_colour_nonzero, aclk, aresetn, m_tvalid && !m_tuser |-> m_tdata[12:6] != 7'd0)
    `BGCO_ASSERT(a_busy_blocks_input, aclk, aresetn, m_tvalid && !m_tlast && !m_tready |-> !s_tready)

endmodule

bind bitset_greedy_colour_order bgco_checker u_bgco_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
